### rtl/zba_pkg.sv
// ----------------------------------------------------------------------------
// zba_pkg
// Shared types and constants of the zone bitmap allocator
// ----------------------------------------------------------------------------
package zba_pkg;

  localparam int unsigned BITS_PER_MAP_BLOCK = 1024;
  localparam int unsigned MAX_MAP_BLOCKS     = 8;
  localparam int unsigned WORD_W             = 64;
  localparam int unsigned WORDS_PER_BLOCK    = BITS_PER_MAP_BLOCK / WORD_W;
  localparam int unsigned MAP_WORDS          = WORDS_PER_BLOCK * MAX_MAP_BLOCKS;

  localparam int unsigned ZONE_W   = 13;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned BIT_W    = $clog2(WORD_W);
  localparam int unsigned WSEL_W   = $clog2(WORDS_PER_BLOCK);
  localparam int unsigned ADDR_W   = $clog2(MAP_WORDS);
  localparam int unsigned BLK_W    = ADDR_W - WSEL_W;
  localparam int unsigned BLKBIT_W = $clog2(BITS_PER_MAP_BLOCK);
  localparam int unsigned TOTAL_W  = ADDR_W + 1;
  localparam int unsigned LIM_W    = ZONE_W + 1;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_FULL    = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic scan_next;
    logic free_rd;
    logic commit_alloc;
    logic commit_free;
    logic set_full;
    logic set_ignored;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic word_free;
    logic last_word;
    logic count_zero;
    logic zone_ok;
    logic out_free;
  } stat_t;

endpackage

### rtl/zba_ram.sv
// ----------------------------------------------------------------------------
// zba_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module zba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/zba_ctrl.sv
// ----------------------------------------------------------------------------
// zba_ctrl
// Request sequencer: allocate scan, free read-modify-write, result hand-off
// ----------------------------------------------------------------------------
module zba_ctrl
  import zba_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  req_free_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ALLOC_RD = 6'b000010,
    S_SCAN     = 6'b000100,
    S_FREE_RD  = 6'b001000,
    S_FREE_WR  = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = req_free_i ? S_FREE_RD : S_ALLOC_RD;
        end
      end
      S_ALLOC_RD: begin
        if (stat_i.count_zero) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat_i.word_free) begin
          cmd_o.commit_alloc = 1'b1;
          state_d            = S_RESP;
        end else if (stat_i.last_word) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.scan_rd   = 1'b1;
          cmd_o.scan_next = 1'b1;
        end
      end
      S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        if (stat_i.zone_ok) begin
          state_d = S_FREE_WR;
        end else begin
          cmd_o.set_ignored = 1'b1;
          state_d           = S_RESP;
        end
      end
      S_FREE_WR: begin
        cmd_o.commit_free = 1'b1;
        state_d           = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/zba_dpath.sv
// ----------------------------------------------------------------------------
// zba_dpath
// Bitmap store, word valid bits, search address, hint, dirty marks, result
// ----------------------------------------------------------------------------
module zba_dpath
  import zba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic [ZONE_W-1:0] zone_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ZONE_W-1:0] out_zone_o,
  output logic [1:0]        out_status_o
);

  logic [CFG_W-1:0]          cfg_q;
  logic [CFG_W-1:0]          count_eff;
  logic [TOTAL_W-1:0]        total_words;
  logic [LIM_W-1:0]          zone_lim;
  logic [ZONE_W-1:0]         zone_q;
  logic [ZONE_W-1:0]         hint_q, hint_d;
  logic [ADDR_W-1:0]         addr_q, addr_next, start_word, raddr, chk_addr_q;
  logic [BLK_W-1:0]          hint_blk;
  logic [ADDR_W-1:0]         n_q;
  logic [MAP_WORDS-1:0]      valid_q;
  logic                      vld_rd_q;
  logic [WORD_W-1:0]         rdata, word, wdata;
  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [BIT_W-1:0]          free_bit;
  logic [MAX_MAP_BLOCKS-1:0] map_block_dirty_q;
  logic                      super_dirty_q;
  logic [ZONE_W-1:0]         pend_zone_q;
  status_e                   pend_status_q;
  logic                      out_valid_q;
  logic [ZONE_W-1:0]         out_zone_q;
  status_e                   out_status_q;

  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  assign count_eff   = (cfg_q > CFG_W'(MAX_MAP_BLOCKS)) ? CFG_W'(MAX_MAP_BLOCKS) : cfg_q;
  assign total_words = TOTAL_W'(count_eff) << WSEL_W;
  assign zone_lim    = LIM_W'(count_eff) << BLKBIT_W;

  assign hint_blk   = hint_q[ZONE_W-1 -: BLK_W];
  assign start_word = ({1'b0, hint_blk} >= CFG_W'(count_eff)) ? '0
                    : ADDR_W'({hint_blk, {WSEL_W{1'b0}}});
  assign addr_next  = ({1'b0, addr_q} == total_words - TOTAL_W'(1)) ? '0
                    : addr_q + ADDR_W'(1);
  assign raddr      = cmd_i.free_rd ? zone_q[ZONE_W-1 -: ADDR_W] : addr_q;

  assign word     = vld_rd_q ? rdata : '0;
  assign free_bit = first_zero(word);

  always_comb begin
    we    = cmd_i.commit_alloc | cmd_i.commit_free;
    waddr = cmd_i.commit_free ? zone_q[ZONE_W-1 -: ADDR_W] : chk_addr_q;
    wdata = cmd_i.commit_free ? (word & ~(WORD_W'(1) << zone_q[BIT_W-1:0]))
                              : (word | (WORD_W'(1) << free_bit));
  end

  always_comb begin
    hint_d = hint_q;
    priority if (cmd_i.commit_alloc) begin
      hint_d = {chk_addr_q, free_bit};
    end else if (cmd_i.commit_free && (zone_q < hint_q)) begin
      hint_d = zone_q;
    end else begin
      hint_d = hint_q;
    end
  end

  assign stat_o.word_free  = ~&word;
  assign stat_o.last_word  = ({1'b0, n_q} == total_words - TOTAL_W'(1));
  assign stat_o.count_zero = (count_eff == '0);
  assign stat_o.zone_ok    = (zone_q != '0) && ({1'b0, zone_q} < zone_lim);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  zba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_addr_q <= raddr;
    if (cmd_i.accept) begin
      zone_q <= zone_i;
      addr_q <= start_word;
      n_q    <= '0;
    end else begin
      if (cmd_i.scan_rd) begin
        addr_q <= addr_next;
      end
      if (cmd_i.scan_next) begin
        n_q <= n_q + ADDR_W'(1);
      end
    end
    if (cmd_i.commit_alloc) begin
      pend_zone_q   <= {chk_addr_q, free_bit};
      pend_status_q <= ST_ALLOC;
    end else if (cmd_i.commit_free) begin
      pend_zone_q   <= '0;
      pend_status_q <= ST_FREED;
    end else if (cmd_i.set_full) begin
      pend_zone_q   <= '0;
      pend_status_q <= ST_FULL;
    end else if (cmd_i.set_ignored) begin
      pend_zone_q   <= '0;
      pend_status_q <= ST_IGNORED;
    end
    if (cmd_i.load_out) begin
      out_zone_q   <= pend_zone_q;
      out_status_q <= pend_status_q;
    end
  end

  // control and allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q             <= CFG_W'(MAX_MAP_BLOCKS);
      hint_q            <= '0;
      valid_q           <= '0;
      vld_rd_q          <= 1'b0;
      map_block_dirty_q <= '0;
      super_dirty_q     <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      hint_q   <= hint_d;
      vld_rd_q <= valid_q[raddr];
      if (we) begin
        valid_q[waddr] <= 1'b1;
        super_dirty_q  <= 1'b1;
        map_block_dirty_q[waddr[ADDR_W-1 -: BLK_W]] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_zone_o   = out_zone_q;
  assign out_status_o = out_status_q;

  a_dirty_implies_super : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_block_dirty_q != '0) |-> super_dirty_q)
    else $error("block dirty without superblock dirty");

  a_load_needs_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> stat_o.out_free)
    else $error("result loaded over an untaken beat");

  a_alloc_word_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_alloc |-> stat_o.word_free)
    else $error("allocation committed on a full word");

  a_free_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_free |-> $past(cmd_i.free_rd) && stat_o.zone_ok)
    else $error("free committed without a checked zone");

endmodule

### rtl/zone_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// zone_bitmap_allocator_unit
// Next-fit zone allocator over a free-zone bitmap of 1024-bit map blocks
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser[0] is 0 to allocate, 1 to free
// the zone in tdata[12:0]. Each request gives one beat on m_axis: the zone
// in tdata[12:0] and the status in tuser[1:0] (allocated, map full, freed,
// ignored or out of range). cfg_we_i writes the number of map blocks in use.
// One request is processed at a time. An allocate scans one 64-bit bitmap
// word per cycle from the start of the hint's map block (block 0 if it is
// not in use), 1 to 16 words per map block in use, at most 128; with no
// block in use it reports map full. A free reads the zone's word and writes
// it back with the bit cleared, skipping the write when ignored or out of
// range. A result is registered as pending, then moved to the output register.
// Reset clears the per-word valid flags of the bitmap RAM at once, so every
// zone reads free with no clearing pass; hint and dirty marks clear too and
// the block count returns to 8. A stalled result is held in the output
// register and a further request is still accepted; that request waits for
// the output slot before its own result is loaded.
// ----------------------------------------------------------------------------
module zone_bitmap_allocator_unit
  import zba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // zone_number [12:0]
  input  logic [0:0]       s_axis_tuser,  // req_type [0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // result_zone [12:0]
  output logic [1:0]       m_axis_tuser   // status [1:0]
);

  cmd_t              cmd;
  stat_t             stat;
  logic [ZONE_W-1:0] out_zone;

  zba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_free_i (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  zba_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .zone_i       (s_axis_tdata[ZONE_W-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_zone_o   (out_zone),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(16 - ZONE_W){1'b0}}, out_zone};

endmodule

### tb/sv/zba_tb_pkg.sv
// ----------------------------------------------------------------------------
// zba_tb_pkg
// Request codes shared by the allocator testbench and its checker
// ----------------------------------------------------------------------------
package zba_tb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

endpackage

### tb/sv/zba_checker.sv
// ----------------------------------------------------------------------------
// zba_checker
// Watches the request, result and block-count ports of the zone allocator,
// keeps its own copy of the bitmap, search hint and block count, predicts the
// grant of every accepted request and compares each result beat in order.
// The count it hands out adds mismatches to grants still awaited.
// ----------------------------------------------------------------------------
module zba_checker
  import zba_pkg::*;
  import zba_tb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,
  input  logic [0:0]       s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [15:0]      m_axis_tdata,
  input  logic [1:0]       m_axis_tuser,
  output int               fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ZONES = BITS_PER_MAP_BLOCK * MAX_MAP_BLOCKS;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    status_e           status;
  } grant_t;

  logic              zone_used [ZONES];
  logic [ZONE_W-1:0] hint;
  logic [CFG_W-1:0]  blocks_cfg;
  grant_t            grant_q [$];
  int unsigned       waiting    = 0;
  int unsigned       mismatches = 0;
  int unsigned       beats_seen = 0;

  assign fail_count_o = mismatches + waiting;

  function automatic int unsigned blocks_eff();
    return (blocks_cfg > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : int'(blocks_cfg);
  endfunction

  // next fit: start of the hint's block, block by block with wrap
  function automatic grant_t allocate_zone();
    int unsigned cnt;
    int unsigned blk;
    int unsigned z;
    grant_t      g;
    g.zone   = '0;
    g.status = ST_FULL;
    cnt      = blocks_eff();
    if (cnt == 0) return g;
    blk = hint / BITS_PER_MAP_BLOCK;
    if (blk >= cnt) blk = 0;
    for (int unsigned n = 0; n < cnt; n++) begin
      for (int unsigned b = 0; b < BITS_PER_MAP_BLOCK; b++) begin
        z = blk * BITS_PER_MAP_BLOCK + b;
        if (!zone_used[z]) begin
          zone_used[z] = 1'b1;
          hint         = z[ZONE_W-1:0];
          g.zone       = z[ZONE_W-1:0];
          g.status     = ST_ALLOC;
          return g;
        end
      end
      blk++;
      if (blk >= cnt) blk = 0;
    end
    return g;
  endfunction

  function automatic grant_t free_zone(input logic [ZONE_W-1:0] zone);
    grant_t g;
    g.zone   = '0;
    g.status = ST_IGNORED;
    if (zone == '0 || int'(zone) >= blocks_eff() * BITS_PER_MAP_BLOCK) return g;
    zone_used[zone] = 1'b0;
    if (zone < hint) hint = zone;
    g.status = ST_FREED;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    if (!rst_ni) begin
      foreach (zone_used[i]) zone_used[i] = 1'b0;
      hint       = '0;
      blocks_cfg = CFG_W'(MAX_MAP_BLOCKS);
      grant_q.delete();
      waiting    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result beat %0d: zone %0d status %0d", $realtime,
                     beats_seen, m_axis_tdata, m_axis_tuser);
        end else begin
          want = grant_q.pop_front();
          waiting--;
          if (m_axis_tdata != 16'(want.zone) || m_axis_tuser != want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t result beat %0d: expected zone %0d status %0d, got zone %0d status %0d",
                       $realtime, beats_seen, want.zone, want.status, m_axis_tdata,
                       m_axis_tuser);
          end
        end
      end
      if (cfg_we_i) blocks_cfg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == REQ_FREE) want = free_zone(s_axis_tdata[ZONE_W-1:0]);
        else want = allocate_zone();
        grant_q.push_back(want);
        waiting++;
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate and free requests into the zone allocator through a range
// of block-count settings, including zone 0, null and double frees, range
// edges, an empty and an oversized count, and growing and shrinking the count.
// Both stream sides idle in random bursts; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_top;

  import zba_pkg::*;
  import zba_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_valid   = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_data    = '0;
  logic [0:0]       s_user    = '0;
  logic             m_axis_tvalid;
  logic             m_ready   = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             quiet     = 1'b0;
  int               fail_count;

  int unsigned n_sent   = 0;
  int unsigned n_done   = 0;
  int unsigned n_alloc  = 0;
  int unsigned n_free   = 0;
  int unsigned n_cfg    = 0;
  int unsigned cur_blks = MAX_MAP_BLOCKS;

  zone_bitmap_allocator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  zba_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_ready) n_done <= n_done + 1;
  end

  // result side back-pressure in bursts
  initial begin : sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        m_ready <= 1'b1;
      end else if (hold > 0) begin
        m_ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 7) == 0) begin
        hold    = $urandom_range(1, 18) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send(input req_e req, input logic [ZONE_W-1:0] zone);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(16 - ZONE_W){1'b0}}, zone};
    s_user  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (req == REQ_ALLOC) n_alloc++;
    else n_free++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
  endtask

  task automatic set_blocks(input logic [CFG_W-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_blks  = (v > MAX_MAP_BLOCKS) ? MAX_MAP_BLOCKS : int'(v);
    n_cfg++;
  endtask

  // frees mostly hit the low zones of a block, where next fit allocates
  task automatic run_mix(input int unsigned items, input int unsigned alloc_pct);
    int unsigned       pick;
    int unsigned       blk;
    logic [ZONE_W-1:0] zone;
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send(REQ_ALLOC, ZONE_W'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        blk  = (cur_blks == 0) ? 0 : $urandom_range(0, cur_blks - 1);
        if (pick < 6) zone = ZONE_W'(blk * BITS_PER_MAP_BLOCK + $urandom_range(0, 95));
        else if (pick < 8) zone = ZONE_W'($urandom_range(0, 8191));
        else if (pick == 8) zone = '0;
        else zone = ZONE_W'(cur_blks * BITS_PER_MAP_BLOCK - $urandom_range(0, 1));
        send(REQ_FREE, zone);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zone 0 first, null free, double free, top zone, alternating bits
    send(REQ_ALLOC, '0);
    send(REQ_ALLOC, 13'h1FFF);
    send(REQ_FREE, '0);
    send(REQ_FREE, 13'd1);
    send(REQ_FREE, 13'd1);
    send(REQ_ALLOC, '0);
    send(REQ_FREE, 13'h1FFF);
    send(REQ_FREE, 13'h1555);
    send(REQ_FREE, 13'h0AAA);
    send(REQ_ALLOC, 13'h1555);
    // no blocks in use
    set_blocks(4'd0);
    send(REQ_ALLOC, '0);
    send(REQ_FREE, 13'd5);
    send(REQ_FREE, '0);
    // count above the maximum
    set_blocks(4'hF);
    send(REQ_FREE, 13'h1FFF);
    send(REQ_ALLOC, '0);
    // range edge
    set_blocks(4'd3);
    send(REQ_FREE, 13'd3072);
    send(REQ_FREE, 13'd3071);
    send(REQ_ALLOC, '0);

    set_blocks(4'd8);
    run_mix(150, 60);
    // one block, allocation heavy, then churn
    set_blocks(4'd1);
    run_mix(120, 80);
    run_mix(40, 50);
    // two blocks, then shrink back to one
    set_blocks(4'd2);
    run_mix(100, 80);
    set_blocks(4'd1);
    run_mix(30, 60);
    set_blocks(4'd9);
    run_mix(80, 60);
    set_blocks(4'd0);
    run_mix(10, 50);
    set_blocks(4'd4);
    quiet = 1'b1;
    run_mix(100, 60);

    drain();
    repeat (150) @(posedge clk_i);
    $display("covered %0d requests: %0d allocate, %0d free", n_sent, n_alloc, n_free);
    $display("block count written %0d times, from 0 up to 15", n_cfg);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/zba_pkg.sv
rtl/zba_ram.sv
rtl/zba_ctrl.sv
rtl/zba_dpath.sv
rtl/zone_bitmap_allocator_unit.sv
tb/sv/zba_tb_pkg.sv
tb/sv/zba_checker.sv
tb/sv/tb_top.sv
